### hw/rtl/hard_sphere_collision_prediction_unit_assert.svh
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef HARD_SPHERE_COLLISION_PREDICTION_UNIT_ASSERT_SVH
`define HARD_SPHERE_COLLISION_PREDICTION_UNIT_ASSERT_SVH

// same-cycle implication
`define HSCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HSCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/hscp_pkg.sv
`default_nettype none

package hscp_pkg;

  localparam int REM_W = 68;
  localparam int SRC_W = 128;

  localparam logic KIND_REF  = 1'b0;
  localparam logic KIND_CAND = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_BOX     = 1'b0;
  localparam logic REG_CONTACT = 1'b1;

  typedef enum logic {
    ITER_DIV,
    ITER_SQRT
  } iter_mode_e;

  typedef struct packed {
    logic       start;
    iter_mode_e mode;
    logic [6:0] steps;
  } iter_req_t;

endpackage

`default_nettype wire

### hw/rtl/hscp_iter.sv
`default_nettype none

module hscp_iter import hscp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  iter_req_t        req_i,
  input  logic [REM_W-1:0] rem_i,
  input  logic [SRC_W-1:0] src_i,
  input  logic [63:0]      div_i,
  output logic             done_o,
  output logic [REM_W-1:0] rem_o,
  output logic [63:0]      quo_o
);

  logic             busy_q;
  logic [6:0]       cnt_q;
  iter_mode_e       mode_q;
  logic [REM_W-1:0] rem_q;
  logic [SRC_W-1:0] src_q;
  logic [63:0]      quo_q;
  logic [63:0]      div_q;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] diff;
  logic             ge;

  // restoring step: one bit of quotient or one bit of root
  always_comb begin
    if (mode_q == ITER_SQRT) begin
      rem_sh = {rem_q[REM_W-3:0], src_q[SRC_W-1 -: 2]};
      trial  = {2'b00, quo_q, 2'b01};
    end else begin
      rem_sh = {rem_q[REM_W-2:0], src_q[SRC_W-1]};
      trial  = {4'b0000, div_q};
    end
    ge   = rem_sh >= trial;
    diff = rem_sh - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mode_q <= req_i.mode;
      rem_q  <= rem_i;
      src_q  <= src_i;
      quo_q  <= '0;
      div_q  <= div_i;
    end else if (busy_q && cnt_q != '0) begin
      rem_q <= ge ? diff : rem_sh;
      quo_q <= {quo_q[62:0], ge};
      src_q <= (mode_q == ITER_SQRT) ? (src_q << 2) : (src_q << 1);
    end
  end

  assign done_o = busy_q && cnt_q == '0;
  assign rem_o  = rem_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

### hw/rtl/hard_sphere_collision_prediction_unit.sv
// candidate: worked through the shared restoring unit: one minimum-image remainder
//   per axis, a 64-step square root and a 32-step divide; dropped candidates finish early
// reference item: taken while idle; a last item also passes FIN before the result is offered
// rst_ni is asynchronous, active low: clears config registers to defaults, reference and search
`default_nettype none
`include "hard_sphere_collision_prediction_unit_assert.svh"

module hard_sphere_collision_prediction_unit import hscp_pkg::*; #(
  parameter int DIMENSIONS    = 3,
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, local_time, particle_id, event_count, bound_time
  input  logic [303:0] s_axis_tdata_i,
  // kind
  input  logic         s_axis_tuser_i,
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // event_time, partner_id, partner_count
  output logic [79:0]  m_axis_tdata_o,
  // improved
  output logic         m_axis_tuser_o
);

  localparam int SEP_W = 68 - FRACTION_BITS;
  localparam int SAT_W = 96 - FRACTION_BITS;
  localparam int SH_W  = 32 - FRACTION_BITS;
  localparam logic [1:0] DIM_LAST = 2'(DIMENSIONS - 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DRIFT = 4'd1;
  localparam logic [3:0] ST_SEP   = 4'd2;
  localparam logic [3:0] ST_MOD   = 4'd3;
  localparam logic [3:0] ST_B     = 4'd4;
  localparam logic [3:0] ST_A     = 4'd5;
  localparam logic [3:0] ST_R     = 4'd6;
  localparam logic [3:0] ST_RACC  = 4'd7;
  localparam logic [3:0] ST_CHK   = 4'd8;
  localparam logic [3:0] ST_WIDE  = 4'd9;
  localparam logic [3:0] ST_ROOT  = 4'd10;
  localparam logic [3:0] ST_SQW   = 4'd11;
  localparam logic [3:0] ST_NUM   = 4'd12;
  localparam logic [3:0] ST_DIV   = 4'd13;
  localparam logic [3:0] ST_KEEP  = 4'd14;
  localparam logic [3:0] ST_FIN   = 4'd15;

  logic [3:0] state_q, state_d;
  logic [1:0] dim_q;
  logic [3:0] wcnt_q;

  logic [30:0] box_q, contact_q;

  logic signed [31:0] ref_pos_q [3];
  logic signed [31:0] ref_vel_q [3];
  logic [31:0] ref_time_q, ref_bound_q;
  logic [15:0] ref_id_q;

  logic [31:0] best_q, best_cnt_q;
  logic [15:0] best_id_q;
  logic        have_q;

  logic signed [31:0] c_pos_q [3];
  logic signed [31:0] c_vel_q [3];
  logic [31:0] c_time_q, c_count_q;
  logic [15:0] c_id_q;
  logic        c_last_q;

  logic signed [65:0]  prod_q;
  logic                sep_neg_q;
  logic signed [31:0]  sepm_q, rel_q;
  logic signed [63:0]  b_q;
  logic [63:0]         a_q, r_q, bpos_q, cq_q, num_q;
  logic signed [128:0] acc_q;
  logic [31:0]         interval_q;

  logic        out_valid_q, out_imp_q;
  logic [31:0] out_time_q, out_cnt_q;
  logic [15:0] out_id_q;

  logic signed [31:0] in_pos [3];
  logic signed [31:0] in_vel [3];
  logic s_fire, fin_go, cfg_wr;

  assign in_pos[0] = s_axis_tdata_i[31:0];
  assign in_pos[1] = s_axis_tdata_i[63:32];
  assign in_pos[2] = s_axis_tdata_i[95:64];
  assign in_vel[0] = s_axis_tdata_i[127:96];
  assign in_vel[1] = s_axis_tdata_i[159:128];
  assign in_vel[2] = s_axis_tdata_i[191:160];

  assign s_axis_tready_o = state_q == ST_IDLE;
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign fin_go = state_q == ST_FIN && (!out_valid_q || m_axis_tready_i);

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_CONTACT) ? {1'b0, contact_q} : {1'b0, box_q};

  // datapath helpers
  logic signed [32:0]  tau, rel_full;
  logic signed [31:0]  v_cur, p_cur, rp_cur, rv_cur, rel_sat;
  logic signed [32:0]  mul_a, mul_b;
  logic signed [65:0]  mul_p;
  logic signed [SEP_W-1:0] sep_d;
  logic [SEP_W-1:0]    mag_d;
  logic [30:0]         len;
  logic [31:0]         len_ext, r_ext, mpos;
  logic signed [31:0]  m_d;
  logic [63:0]         contact_sh;
  logic signed [63:0]  c_d;
  logic                chk_drop, sat;
  logic [2:0]          wk;
  logic [63:0]         wx, wy;
  logic [128:0]        term;
  logic signed [33:0]  limit;
  logic                improved;
  logic [32:0]         ev_sum;
  logic [3:0]          drop_st;
  logic                iter_wait;

  iter_req_t        iter_req;
  logic [REM_W-1:0] iter_rem_in, iter_rem;
  logic [SRC_W-1:0] iter_src;
  logic [63:0]      iter_div, iter_quo;
  logic             iter_done;

  assign tau    = $signed({1'b0, ref_time_q}) - $signed({1'b0, c_time_q});
  assign v_cur  = c_vel_q[dim_q];
  assign p_cur  = c_pos_q[dim_q];
  assign rp_cur = ref_pos_q[dim_q];
  assign rv_cur = ref_vel_q[dim_q];
  assign len    = (box_q == '0) ? 31'd1 : box_q;

  assign sep_d = $signed(SEP_W'(prod_q >>> FRACTION_BITS)) + SEP_W'(p_cur) - SEP_W'(rp_cur);
  assign mag_d = sep_d[SEP_W-1] ? SEP_W'(-sep_d) : sep_d;

  assign rel_full = 33'(v_cur) - 33'(rv_cur);
  always_comb begin
    if (rel_full[32] != rel_full[31]) begin
      rel_sat = rel_full[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      rel_sat = rel_full[31:0];
    end
  end

  // minimum image from the remainder modulo the box length
  assign len_ext = {1'b0, len};
  assign r_ext   = {1'b0, iter_rem[30:0]};
  assign mpos    = ({iter_rem[30:0], 1'b0} >= len_ext) ? r_ext - len_ext : r_ext;
  assign m_d     = sep_neg_q ? -$signed(mpos) : $signed(mpos);

  assign contact_sh = 64'(contact_q) << FRACTION_BITS;
  assign c_d        = $signed(r_q) - $signed(contact_sh);
  assign chk_drop   = !b_q[63] || c_d[63] || a_q == '0;

  assign sat = SAT_W'(num_q) >= (SAT_W'(a_q) << SH_W);

  // wide products: partials of bpos*bpos added, of a*c subtracted
  assign wk = 3'(wcnt_q - 4'd1);
  always_comb begin
    unique case (wk[1:0])
      2'd0:    term = 129'(prod_q[63:0]);
      2'd3:    term = 129'(prod_q[63:0]) << 64;
      default: term = 129'(prod_q[63:0]) << 32;
    endcase
  end
  assign wx = wcnt_q[2] ? a_q : bpos_q;
  assign wy = wcnt_q[2] ? cq_q : bpos_q;

  always_comb begin
    unique case (state_q)
      ST_DRIFT: begin
        mul_a = 33'(v_cur);
        mul_b = tau;
      end
      ST_B: begin
        mul_a = 33'(sepm_q);
        mul_b = 33'(rel_q);
      end
      ST_A: begin
        mul_a = 33'(rel_q);
        mul_b = 33'(rel_q);
      end
      ST_R: begin
        mul_a = 33'(sepm_q);
        mul_b = 33'(sepm_q);
      end
      ST_WIDE: begin
        mul_a = $signed({1'b0, wcnt_q[1] ? wx[63:32] : wx[31:0]});
        mul_b = $signed({1'b0, wcnt_q[0] ? wy[63:32] : wy[31:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    iter_req       = '0;
    iter_req.mode  = ITER_DIV;
    iter_rem_in    = '0;
    iter_src       = '0;
    iter_div       = {33'd0, len};
    unique case (state_q)
      ST_SEP: begin
        iter_req.start = 1'b1;
        iter_req.steps = 7'(SEP_W);
        iter_src       = {mag_d, {(SRC_W-SEP_W){1'b0}}};
      end
      ST_ROOT: begin
        iter_req.start = !acc_q[128];
        iter_req.mode  = ITER_SQRT;
        iter_req.steps = 7'd64;
        iter_src       = acc_q[127:0];
      end
      ST_NUM: begin
        iter_req.start = !sat;
        iter_req.steps = 7'd32;
        iter_rem_in    = REM_W'(num_q >> SH_W);
        iter_src       = {num_q[SH_W-1:0], {(SRC_W-SH_W){1'b0}}};
        iter_div       = a_q;
      end
      default: ;
    endcase
  end

  hscp_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iter_req),
    .rem_i  (iter_rem_in),
    .src_i  (iter_src),
    .div_i  (iter_div),
    .done_o (iter_done),
    .rem_o  (iter_rem),
    .quo_o  (iter_quo)
  );

  assign limit    = $signed({2'b00, ref_bound_q}) - $signed({2'b00, ref_time_q});
  assign improved = have_q && ($signed({2'b00, best_q}) < limit);
  assign ev_sum   = {1'b0, ref_time_q} + {1'b0, best_q};
  assign drop_st  = c_last_q ? ST_FIN : ST_IDLE;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser_i == KIND_REF) begin
            state_d = s_axis_tlast_i ? ST_FIN : ST_IDLE;
          end else begin
            state_d = ST_DRIFT;
          end
        end
      end
      ST_DRIFT: state_d = (c_id_q == ref_id_q) ? drop_st : ST_SEP;
      ST_SEP:   state_d = ST_MOD;
      ST_MOD:   if (iter_done) state_d = ST_B;
      ST_B:     state_d = ST_A;
      ST_A:     state_d = ST_R;
      ST_R:     state_d = ST_RACC;
      ST_RACC:  state_d = (dim_q == DIM_LAST) ? ST_CHK : ST_DRIFT;
      ST_CHK:   state_d = chk_drop ? drop_st : ST_WIDE;
      ST_WIDE:  if (wcnt_q == 4'd8) state_d = ST_ROOT;
      ST_ROOT:  state_d = acc_q[128] ? drop_st : ST_SQW;
      ST_SQW:   if (iter_done) state_d = ST_NUM;
      ST_NUM:   state_d = sat ? ST_KEEP : ST_DIV;
      ST_DIV:   if (iter_done) state_d = ST_KEEP;
      ST_KEEP:  state_d = drop_st;
      ST_FIN:   if (fin_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dim_q       <= '0;
      wcnt_q      <= '0;
      box_q       <= 31'd65536;
      contact_q   <= 31'd65536;
      for (int i = 0; i < 3; i++) begin
        ref_pos_q[i] <= '0;
        ref_vel_q[i] <= '0;
      end
      ref_time_q  <= '0;
      ref_id_q    <= '0;
      ref_bound_q <= '1;
      best_q      <= '1;
      best_id_q   <= '0;
      best_cnt_q  <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        if (paddr[2] == REG_BOX) begin
          box_q <= pwdata[30:0];
        end else begin
          contact_q <= pwdata[30:0];
        end
      end
      if (s_fire) begin
        dim_q <= '0;
        if (s_axis_tuser_i == KIND_REF) begin
          for (int i = 0; i < 3; i++) begin
            ref_pos_q[i] <= in_pos[i];
            ref_vel_q[i] <= in_vel[i];
          end
          ref_time_q  <= s_axis_tdata_i[223:192];
          ref_id_q    <= s_axis_tdata_i[239:224];
          ref_bound_q <= s_axis_tdata_i[303:272];
          best_q      <= '1;
          best_id_q   <= '0;
          best_cnt_q  <= '0;
          have_q      <= 1'b0;
        end
      end
      if (state_q == ST_RACC && dim_q != DIM_LAST) begin
        dim_q <= dim_q + 2'd1;
      end
      if (state_q == ST_CHK) begin
        wcnt_q <= '0;
      end else if (state_q == ST_WIDE) begin
        wcnt_q <= wcnt_q + 4'd1;
      end
      if (state_q == ST_KEEP && (!have_q || interval_q < best_q)) begin
        best_q     <= interval_q;
        best_id_q  <= c_id_q;
        best_cnt_q <= c_count_q;
        have_q     <= 1'b1;
      end
      if (fin_go) begin
        best_q      <= '1;
        best_id_q   <= '0;
        best_cnt_q  <= '0;
        have_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (s_fire && s_axis_tuser_i == KIND_CAND) begin
      for (int i = 0; i < 3; i++) begin
        c_pos_q[i] <= in_pos[i];
        c_vel_q[i] <= in_vel[i];
      end
      c_time_q  <= s_axis_tdata_i[223:192];
      c_id_q    <= s_axis_tdata_i[239:224];
      c_count_q <= s_axis_tdata_i[271:240];
      c_last_q  <= s_axis_tlast_i;
      b_q       <= '0;
      a_q       <= '0;
      r_q       <= '0;
    end
    unique case (state_q)
      ST_SEP: begin
        sep_neg_q <= sep_d[SEP_W-1];
        rel_q     <= rel_sat;
      end
      ST_MOD:  if (iter_done) sepm_q <= m_d;
      ST_A:    b_q <= b_q + $signed(prod_q[63:0]);
      ST_R:    a_q <= a_q + prod_q[63:0];
      ST_RACC: r_q <= r_q + prod_q[63:0];
      ST_CHK: begin
        bpos_q <= 64'(-b_q);
        cq_q   <= c_d;
        acc_q  <= '0;
      end
      ST_WIDE: begin
        if (wcnt_q != '0) begin
          acc_q <= wk[2] ? acc_q - $signed(term) : acc_q + $signed(term);
        end
      end
      ST_SQW:  if (iter_done) num_q <= bpos_q - iter_quo;
      ST_NUM:  if (sat) interval_q <= '1;
      ST_DIV:  if (iter_done) interval_q <= iter_quo[31:0];
      default: ;
    endcase
    if (fin_go) begin
      out_imp_q <= improved;
      if (improved) begin
        out_time_q <= ev_sum[32] ? 32'hffff_ffff : ev_sum[31:0];
        out_id_q   <= best_id_q;
        out_cnt_q  <= best_cnt_q;
      end else begin
        out_time_q <= ref_bound_q;
        out_id_q   <= '0;
        out_cnt_q  <= '0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_imp_q;
  assign m_axis_tdata_o  = {out_cnt_q, out_id_q, out_time_q};

  assign iter_wait = state_q == ST_MOD || state_q == ST_SQW || state_q == ST_DIV;

  `HSCP_ASSERT_IMP(a_iter_done_waited, iter_done, iter_wait, "shared unit done outside a wait")
  `HSCP_ASSERT_IMP(a_out_from_fin, $rose(out_valid_q), $past(state_q) == ST_FIN, "result early")
  `HSCP_ASSERT_IMP(a_wide_count, state_q == ST_WIDE, wcnt_q <= 4'd8, "wide counter overran")
  `HSCP_ASSERT_IMP(a_root_bound, state_q == ST_SQW && iter_done, iter_quo <= bpos_q, "root high")
  `HSCP_ASSERT_IMP(a_no_self_partner, have_q, best_id_q != ref_id_q, "reference is own partner")

endmodule

`default_nettype wire

### verif/tb.sv
`default_nettype none

module tb;
  import hscp_pkg::*;

  localparam int U = 65536;
  localparam int FB = 16;
  localparam longint LIMIT = 3000000;

  typedef struct {
    bit        kind;
    bit [31:0] pos[3];
    bit [31:0] vel[3];
    bit [31:0] lt;
    bit [15:0] id;
    bit [31:0] cnt;
    bit [31:0] bound;
    bit        last;
  } particle_t;

  typedef struct {
    bit        imp;
    bit [31:0] et;
    bit [15:0] pid;
    bit [31:0] pc;
  } collision_t;

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_vld = 0;
  logic s_rdy;
  logic [303:0] s_data = '0;
  logic s_user = 0, s_last = 0;
  logic m_vld;
  logic m_rdy = 0;
  logic [79:0] m_data;
  logic m_user;

  hard_sphere_collision_prediction_unit DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_axis_tvalid_i(s_vld), .s_axis_tready_o(s_rdy), .s_axis_tdata_i(s_data),
    .s_axis_tuser_i(s_user), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_o(m_vld), .m_axis_tready_i(m_rdy), .m_axis_tdata_o(m_data),
    .m_axis_tuser_o(m_user)
  );

  initial forever #10 clk = ~clk;

  // predictor state
  bit [30:0] box_len = 31'(U);
  bit [30:0] contact_sq = 31'(U);
  longint ref_pos[3] = '{0, 0, 0};
  longint ref_vel[3] = '{0, 0, 0};
  bit [31:0] ref_t = 0;
  bit [15:0] ref_pid = 0;
  bit [31:0] ref_bnd = '1;
  bit [31:0] best_int = '1;
  bit [15:0] best_pid = 0;
  bit [31:0] best_cnt = 0;
  bit have_best = 0;

  particle_t pending[$];
  collision_t expected[$];
  particle_t cur;
  bit in_acc = 0;
  int mode = 0;
  int errors = 0;
  longint cycles = 0;
  bit hold_arm = 0, hold_used = 0;
  int hold_cnt = 0;

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic void add_item(particle_t it);
    pending = {pending, it};
  endfunction

  function automatic longint wrap_image(longint x, longint unsigned len);
    longint unsigned mag, k;
    longint m;
    mag = x < 0 ? -x : x;
    k = (2 * mag + len) / (2 * len);
    m = longint'(mag - k * len);
    return x < 0 ? -m : m;
  endfunction

  function automatic void clear_best();
    best_int = '1;
    best_pid = 0;
    best_cnt = 0;
    have_best = 0;
  endfunction

  function automatic void try_partner(particle_t it);
    longint tau, p, v, sep, rel, bsum, rsum, csum;
    longint unsigned asum, len, bpos, root, num, q, t, intv, frac;
    bit [64:0] rem;
    bit [127:0] sq, prod, rad;
    tau = $signed({32'b0, ref_t}) - $signed({32'b0, it.lt});
    len = box_len == 0 ? 1 : box_len;
    bsum = 0; rsum = 0; asum = 0; frac = 0;
    if (it.id == ref_pid) return;
    for (int d = 0; d < 3; d++) begin
      p = longint'($signed(it.pos[d]));
      v = longint'($signed(it.vel[d]));
      sep = p + ((v * tau) >>> FB) - ref_pos[d];
      rel = v - ref_vel[d];
      sep = wrap_image(sep, len);
      if (rel > 64'sd2147483647) rel = 64'sd2147483647;
      if (rel < -64'sd2147483648) rel = -64'sd2147483648;
      bsum += sep * rel;
      asum += longint'(rel * rel);
      rsum += sep * sep;
    end
    if (bsum >= 0) return;
    csum = rsum - (longint'(contact_sq) <<< FB);
    if (csum < 0 || asum == 0) return;
    bpos = -bsum;
    sq = {64'b0, bpos} * {64'b0, bpos};
    prod = {64'b0, asum} * {64'b0, csum};
    if (prod > sq) return;
    rad = sq - prod;
    root = 0;
    for (int b = 63; b >= 0; b--) begin
      t = root | (64'd1 << b);
      if ({64'b0, t} * {64'b0, t} <= rad) root = t;
    end
    num = bpos - root;
    q = num / asum;
    rem = {1'b0, num % asum};
    if (q > 64'hFFFF) intv = 64'hFFFF_FFFF;
    else begin
      for (int d = 0; d < FB; d++) begin
        rem = rem << 1;
        frac = frac << 1;
        if (rem >= {1'b0, asum}) begin
          rem = rem - {1'b0, asum};
          frac |= 1;
        end
      end
      intv = (q << FB) | frac;
    end
    if (!have_best || intv < best_int) begin
      best_int = intv[31:0];
      best_pid = it.id;
      best_cnt = it.cnt;
      have_best = 1;
    end
  endfunction

  function automatic void predict(particle_t it);
    collision_t r;
    longint unsigned sum;
    if (it.kind == KIND_REF) begin
      for (int d = 0; d < 3; d++) begin
        ref_pos[d] = longint'($signed(it.pos[d]));
        ref_vel[d] = longint'($signed(it.vel[d]));
      end
      ref_t = it.lt;
      ref_pid = it.id;
      ref_bnd = it.bound;
      clear_best();
    end else try_partner(it);
    if (!it.last) return;
    if (have_best && $signed({32'b0, best_int}) <
        $signed({32'b0, ref_bnd}) - $signed({32'b0, ref_t})) begin
      sum = {32'b0, ref_t} + {32'b0, best_int};
      r.imp = 1;
      r.et = sum > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : sum[31:0];
      r.pid = best_pid;
      r.pc = best_cnt;
    end else begin
      r.imp = 0;
      r.et = ref_bnd;
      r.pid = 0;
      r.pc = 0;
    end
    expected = {expected, r};
    clear_best();
  endfunction

  // input and output monitor
  always @(posedge clk) begin
    collision_t e;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
    in_acc <= s_vld && s_rdy;
    if (rst_n && s_vld && s_rdy) predict(cur);
    if (rst_n && m_vld && m_rdy) begin
      if (expected.size() == 0) report("unexpected result", m_data, 0);
      else begin
        e = expected.pop_front();
        if (m_user !== e.imp) report("improved", m_user, e.imp);
        if (m_data[31:0] !== e.et) report("event_time", m_data[31:0], e.et);
        if (m_data[47:32] !== e.pid) report("partner_id", m_data[47:32], e.pid);
        if (m_data[79:48] !== e.pc) report("partner_count", m_data[79:48], e.pc);
      end
    end
  end

  // long receiver stall, taken once
  always @(posedge clk) begin
    if (hold_cnt == 0 && hold_arm && !hold_used) begin
      hold_cnt <= 2500;
      hold_used <= 1;
    end else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  // driver
  always @(negedge clk) begin
    particle_t it;
    bit idle;
    if (rst_n) begin
      if (!s_vld || in_acc) begin
        idle = (mode == 1 && $urandom_range(0, 99) < 84) ||
               (mode == 3 && $urandom_range(0, 99) < 19);
        if (pending.size() != 0 && !idle) begin
          it = pending.pop_front();
          cur <= it;
          s_data <= {it.bound, it.cnt, it.id, it.lt, it.vel[2], it.vel[1], it.vel[0],
                     it.pos[2], it.pos[1], it.pos[0]};
          s_user <= it.kind;
          s_last <= it.last;
          s_vld <= 1;
        end else s_vld <= 0;
      end
      m_rdy <= hold_cnt == 0 &&
               !(mode == 2 && $urandom_range(0, 99) < 84) &&
               !(mode == 3 && $urandom_range(0, 99) < 19);
    end
  end

  function automatic particle_t mk(bit kind, int px, int py, int pz, int vx, int vy, int vz,
                                   bit [31:0] lt, bit [15:0] id, bit [31:0] cnt,
                                   bit [31:0] bound, bit last);
    particle_t it;
    it.kind = kind;
    it.pos = '{px, py, pz};
    it.vel = '{vx, vy, vz};
    it.lt = lt; it.id = id; it.cnt = cnt; it.bound = bound; it.last = last;
    return it;
  endfunction

  function automatic int srnd(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  task automatic reg_write(bit idx, bit [31:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == REG_BOX) box_len = val[30:0];
    else contact_sq = val[30:0];
  endtask

  task automatic drain();
    while (pending.size() != 0 || s_vld || expected.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic gen_query();
    bit [31:0] t0, bnd;
    int rp[3], rv[3], n;
    bit [15:0] rid;
    particle_t it;
    if ($urandom_range(0, 9) == 0) begin
      it = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom);
      add_item(it);
      return;
    end
    t0 = $urandom_range(0, 1 << 24);
    for (int d = 0; d < 3; d++) begin
      rp[d] = srnd(4 * U);
      rv[d] = srnd(U);
    end
    rid = $urandom_range(0, 15);
    case ($urandom_range(0, 3))
      0: bnd = '1;
      1: bnd = t0 + $urandom_range(0, 8 * U);
      2: bnd = $urandom_range(0, t0);
      default: bnd = $urandom;
    endcase
    n = $urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 6);
    add_item(mk(KIND_REF, rp[0], rp[1], rp[2], rv[0], rv[1], rv[2], t0, rid,
                $urandom, bnd, n == 0));
    for (int i = 0; i < n; i++)
      add_item(mk(KIND_CAND, rp[0] + srnd(3 * U), rp[1] + srnd(3 * U),
                  rp[2] + srnd(3 * U), rv[0] + srnd(2 * U), rv[1] + srnd(2 * U),
                  rv[2] + srnd(2 * U), t0 - $urandom_range(0, U),
                  $urandom_range(0, 15), $urandom, $urandom, i == n - 1));
  endtask

  bit [31:0] box_set[4] = '{10 * U, 0, 32'h7FFF_FFFF, 20 * U};
  bit [31:0] cd_set[4] = '{U, 32'h7FFF_FFFF, 1, 4 * U};

  initial begin
    int base;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // candidate against the reset reference
    add_item(mk(KIND_CAND, 2 * U, 0, 0, -U, 0, 0, 0, 5, 7, 0, 1));
    drain();
    reg_write(REG_BOX, 10 * U);
    reg_write(REG_CONTACT, U);
    add_item(mk(KIND_REF, 0, 0, 0, 0, 0, 0, U, 1, 0, '1, 1));
    add_item(mk(KIND_REF, 0, 0, 0, 0, 0, 0, U, 1, 0, '1, 0));
    add_item(mk(KIND_CAND, 3 * U, 0, 0, -U, 0, 0, U, 2, 22, 0, 0));
    add_item(mk(KIND_CAND, -3 * U, 0, 0, -U, 0, 0, U, 3, 33, 0, 0));
    add_item(mk(KIND_CAND, 2 * U, 0, 0, -U, 0, 0, U, 1, 11, 0, 0));
    add_item(mk(KIND_CAND, 3 * U, 3 * U, 0, -U, 0, 0, U, 4, 44, 0, 0));
    add_item(mk(KIND_CAND, U / 2, 0, 0, -U, 0, 0, U, 5, 55, 0, 0));
    add_item(mk(KIND_CAND, 3 * U, 0, 0, -U, 0, 0, U, 6, 66, 0, 0));
    add_item(mk(KIND_CAND, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1, '1, '1, 1));
    add_item(mk(KIND_REF, 0, 0, 0, 0, 0, 0, 4 * U, 1, 0, 4 * U, 0));
    add_item(mk(KIND_CAND, 3 * U, 0, 0, -U, 0, 0, 4 * U, 2, 9, 0, 1));
    add_item(mk(KIND_REF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, '1, '1, 0, 0));
    add_item(mk(KIND_CAND, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(REG_BOX, box_set[ph / 2]);
      reg_write(REG_CONTACT, cd_set[ph / 2]);
      mode = ph % 4;
      base = pending.size();
      while (pending.size() - base < 135) gen_query();
      // close the phase with a query so the block ends idle
      add_item(mk(KIND_REF, 0, 0, 0, 0, 0, 0, 0, 1, 0, '1, 1));
      if (ph == 0) hold_arm = 1;
      drain();
    end
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
